// ===== hdl/hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types, constants and arctangent table of the superposition phase
// block.
// ----------------------------------------------------------------------------
package hsp_pkg;

	localparam int MAX_SPOTS_DEF = 64;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN = 24;

	localparam int CFG_W = 32;
	localparam int CFG_AW = 2;

	typedef enum logic [CFG_AW-1:0] {
		REG_SPOT_COUNT = 2'd0,
		REG_LIN_GAIN   = 2'd1,
		REG_QUAD_GAIN  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_index_t;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_COMPUTE = 1'b1
	} command_t;

	localparam int ROT_XW = 27;
	localparam int ROT_ZW = 34;
	localparam int VEC_XW = 35;
	localparam int VEC_ZW = 34;
	localparam logic [31:0] ROT_X0 = 32'd10188014;

	typedef logic [31:0] atan_table_t [0:ATAN_LEN-1];

	localparam atan_table_t ATAN_TURNS = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	function automatic logic [31:0] atan_turn(input int step);
		return ATAN_TURNS[step];
	endfunction

endpackage

// ===== hdl/hsp_ram.sv =====
// ----------------------------------------------------------------------------
// hsp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hsp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== hdl/hsp_cell.sv =====
// ----------------------------------------------------------------------------
// hsp_cell
// One CORDIC micro-rotation step, registered. Rotation mode steers by the
// sign of the residual angle, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module hsp_cell
	import hsp_pkg::*;
#(
	parameter int XW = ROT_XW,
	parameter int ZW = ROT_ZW,
	parameter int STEP = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_flag,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	output logic                 out_valid_q,
	output logic                 out_flag_q,
	output logic signed [XW-1:0] out_x_q,
	output logic signed [XW-1:0] out_y_q,
	output logic signed [ZW-1:0] out_z_q
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(STEP));

	logic                 up;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	assign up = VECTOR ? in_y[XW-1] : !in_z[ZW-1];
	assign xs = in_x >>> STEP;
	assign ys = in_y >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_flag_q <= in_flag;
		if (up) begin
			out_x_q <= in_x - ys;
			out_y_q <= in_y + xs;
			out_z_q <= in_z - ATAN;
		end else begin
			out_x_q <= in_x + ys;
			out_y_q <= in_y - xs;
			out_z_q <= in_z + ATAN;
		end
	end

endmodule

// ===== hdl/hologram_superposition_phase.sv =====
// One compute word at a time: busy stays high from the accept of a compute word until
// its result is strobed. A load word is written into the spot table on accept and
// does not raise busy.
// Reset clears control state and the configuration registers; the spot table is not cleared.
// Results are strobed for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// hologram_superposition_phase
// Sums unit phasors over the spot table for each pupil point and returns the
// argument of the sum, using rows of CORDIC cells.
// ----------------------------------------------------------------------------
module hologram_superposition_phase
	import hsp_pkg::*;
#(
	parameter int MAX_SPOTS = MAX_SPOTS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [5:0]        spot_index,
	input  logic signed [15:0] spot_x,
	input  logic signed [15:0] spot_y,
	input  logic signed [15:0] spot_z,
	input  logic [15:0]       spot_piston,
	input  logic signed [15:0] pupil_x,
	input  logic signed [15:0] pupil_y,
	input  logic              last_point,
	output logic              done,
	output logic signed [15:0] phase_out,
	output logic              last_point_out
);

	localparam int NS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam int AW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
	localparam int CW = $clog2(MAX_SPOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_ISSUE, ST_DRAIN, ST_VEC_GO, ST_VEC_WAIT
	} state_t;

	state_t state_q;

	logic [6:0]         spot_count_q;
	logic signed [31:0] lin_gain_q;
	logic signed [31:0] quad_gain_q;

	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic               last_q;
	logic [31:0]        r2_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      acc_cnt_q;
	logic signed [23:0] sum_re_q;
	logic signed [23:0] sum_im_q;
	logic               done_q;
	logic signed [15:0] phase_q;
	logic               last_out_q;

	logic               accept;
	logic [CW-1:0]      n_sat;
	logic               wr_en;
	logic [63:0]        rd_data;
	logic               issue;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign issue = (state_q == ST_ISSUE);
	assign n_sat = (32'(spot_count_q) > 32'(MAX_SPOTS)) ? CW'(MAX_SPOTS) : CW'(spot_count_q);
	assign wr_en = accept && (command == CMD_LOAD) && (32'(spot_index) < 32'(MAX_SPOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_count_q <= '0;
			lin_gain_q <= '0;
			quad_gain_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_addr))
				REG_SPOT_COUNT: spot_count_q <= cfg_data[6:0];
				REG_LIN_GAIN:   lin_gain_q <= cfg_data;
				REG_QUAD_GAIN:  quad_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hsp_ram #(.WIDTH(64), .DEPTH(MAX_SPOTS), .AW(AW)) u_table (
		.clk(clk),
		.we(wr_en),
		.waddr(AW'(spot_index)),
		.wdata({spot_x, spot_y, spot_z, spot_piston}),
		.raddr(k_q[AW-1:0]),
		.rdata_q(rd_data)
	);

	// Spot pipeline ahead of the rotation cells.
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [32:0] dot_s2;
	logic signed [32:0] zr_s2;
	logic [15:0]        pist_s2, pist_s3;
	logic [31:0]        lin_s3, quad_s3;

	logic signed [31:0] xp, yp;
	logic signed [48:0] zr_full;
	logic signed [64:0] lin_prod, quad_prod;
	logic [31:0]        ang, ang_f;
	logic               ang_neg;

	assign xp = $signed(rd_data[63:48]) * px_q;
	assign yp = $signed(rd_data[47:32]) * py_q;
	assign zr_full = $signed(rd_data[31:16]) * $signed({1'b0, r2_q});
	assign lin_prod = lin_gain_q * dot_s2;
	assign quad_prod = quad_gain_q * zr_s2;
	assign ang = lin_s3 + quad_s3 + {pist_s3, 16'b0};
	assign ang_neg = ang[31] ^ ang[30];
	assign ang_f = ang_neg ? (ang - 32'h8000_0000) : ang;

	logic                     rv [0:NS];
	logic                     rf [0:NS];
	logic signed [ROT_XW-1:0] rx [0:NS];
	logic signed [ROT_XW-1:0] ry [0:NS];
	logic signed [ROT_ZW-1:0] rz [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	logic                     neg_s4;
	logic signed [ROT_ZW-1:0] z_s4;

	always_ff @(posedge clk) begin
		dot_s2 <= 33'(xp) + 33'(yp);
		zr_s2 <= zr_full[47:15];
		pist_s2 <= rd_data[15:0];
		lin_s3 <= lin_prod[53:22];
		quad_s3 <= quad_prod[53:22];
		pist_s3 <= pist_s2;
		neg_s4 <= ang_neg;
		z_s4 <= ROT_ZW'($signed(ang_f));
	end

	assign rv[0] = valid_s4;
	assign rf[0] = neg_s4;
	assign rx[0] = ROT_XW'(ROT_X0);
	assign ry[0] = '0;
	assign rz[0] = z_s4;

	for (genvar i = 0; i < NS; i++) begin : g_rot
		hsp_cell #(.XW(ROT_XW), .ZW(ROT_ZW), .STEP(i), .VECTOR(1'b0)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(rv[i]), .in_flag(rf[i]),
			.in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]),
			.out_valid_q(rv[i+1]), .out_flag_q(rf[i+1]),
			.out_x_q(rx[i+1]), .out_y_q(ry[i+1]), .out_z_q(rz[i+1])
		);
	end

	// Rounding and sign of the phasor, then accumulation.
	logic signed [ROT_XW-1:0] cr, sr;
	logic signed [23:0]       c_s5, s_s5;
	logic                     valid_s5;

	assign cr = (rx[NS] + ROT_XW'(128)) >>> 8;
	assign sr = (ry[NS] + ROT_XW'(128)) >>> 8;

	always_ff @(posedge clk) begin
		c_s5 <= rf[NS] ? -24'(cr) : 24'(cr);
		s_s5 <= rf[NS] ? -24'(sr) : 24'(sr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= rv[NS];
		end
	end

	// Argument of the sum.
	logic                     vv [0:NS];
	logic                     vf [0:NS];
	logic signed [VEC_XW-1:0] vx [0:NS];
	logic signed [VEC_XW-1:0] vy [0:NS];
	logic signed [VEC_ZW-1:0] vz [0:NS];
	logic signed [VEC_XW-1:0] re_sc, im_sc;
	logic [31:0]              ph;

	assign re_sc = VEC_XW'(sum_re_q) <<< 8;
	assign im_sc = VEC_XW'(sum_im_q) <<< 8;
	assign vv[0] = (state_q == ST_VEC_GO);
	assign vf[0] = sum_re_q[23];
	assign vx[0] = sum_re_q[23] ? -re_sc : re_sc;
	assign vy[0] = sum_re_q[23] ? -im_sc : im_sc;
	assign vz[0] = '0;

	for (genvar i = 0; i < NS; i++) begin : g_vec
		hsp_cell #(.XW(VEC_XW), .ZW(VEC_ZW), .STEP(i), .VECTOR(1'b1)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(vv[i]), .in_flag(vf[i]),
			.in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]),
			.out_valid_q(vv[i+1]), .out_flag_q(vf[i+1]),
			.out_x_q(vx[i+1]), .out_y_q(vy[i+1]), .out_z_q(vz[i+1])
		);
	end

	assign ph = {vf[NS], 31'b0} + vz[NS][31:0] + 32'h0000_8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			px_q <= '0;
			py_q <= '0;
			last_q <= 1'b0;
			r2_q <= '0;
			n_q <= '0;
			k_q <= '0;
			acc_cnt_q <= '0;
			sum_re_q <= '0;
			sum_im_q <= '0;
			done_q <= 1'b0;
			phase_q <= '0;
			last_out_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (valid_s5) begin
				sum_re_q <= sum_re_q + c_s5;
				sum_im_q <= sum_im_q + s_s5;
				acc_cnt_q <= acc_cnt_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_COMPUTE) begin
						px_q <= pupil_x;
						py_q <= pupil_y;
						last_q <= last_point;
						n_q <= n_sat;
						k_q <= '0;
						acc_cnt_q <= '0;
						sum_re_q <= '0;
						sum_im_q <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					r2_q <= 32'(px_q) * 32'(px_q) + 32'(py_q) * 32'(py_q);
					state_q <= (n_q == '0) ? ST_VEC_GO : ST_ISSUE;
				end
				ST_ISSUE: begin
					k_q <= k_q + CW'(1);
					if (k_q == n_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (acc_cnt_q == n_q) begin
						state_q <= ST_VEC_GO;
					end
				end
				ST_VEC_GO: begin
					state_q <= ST_VEC_WAIT;
				end
				ST_VEC_WAIT: begin
					if (vv[NS]) begin
						done_q <= 1'b1;
						phase_q <= (sum_re_q == '0 && sum_im_q == '0) ? 16'sd0 :
							$signed(ph[31:16]);
						last_out_q <= last_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign phase_out = phase_q;
	assign last_point_out = last_out_q;

endmodule

// ===== hdl/hsp_checker.sv =====
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks of the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module hsp_checker
	import hsp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic done
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without a result");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_COMPUTE |=> busy)
		else $error("compute word did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_LOAD |=> !busy && !done)
		else $error("load word raised busy or a result");

endmodule

bind hologram_superposition_phase hsp_checker u_hsp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.command(command),
	.done(done)
);

// ===== tb/sv/hologram_superposition_phase_tb.sv =====
// ----------------------------------------------------------------------------
// hologram_superposition_phase_tb
// Loads spot tables and sends pupil points through the superposition phase
// block, predicting most phase words in fixed point, checking all on done.
// ----------------------------------------------------------------------------
module hologram_superposition_phase_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hsp_pkg::*;

	localparam int N_SPOTS = 64;
	localparam int N_STEPS = 16;
	localparam int SETTLE = N_SPOTS + 2 * N_STEPS + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic command = 1'b0;
	logic [5:0] spot_index = '0;
	logic signed [15:0] spot_x = '0, spot_y = '0, spot_z = '0;
	logic [15:0] spot_piston = '0;
	logic signed [15:0] pupil_x = '0, pupil_y = '0;
	logic last_point = 1'b0;
	logic done;
	logic signed [15:0] phase_out;
	logic last_point_out;

	typedef struct packed {
		logic [15:0] phase;
		logic last;
	} phase_word_t;

	typedef struct {
		command_t cmd;
		logic [5:0] idx;
		logic [15:0] sx, sy, sz, sp, px, py;
		logic last;
		logic check;
		logic [15:0] phase;
	} stim_row_t;

	phase_word_t phase_q[$];
	logic signed [63:0] tab_x[N_SPOTS], tab_y[N_SPOTS], tab_z[N_SPOTS];
	logic [31:0] tab_p[N_SPOTS];
	int unsigned n_used;
	logic signed [63:0] g_lin, g_quad;
	int errors = 0;
	int n_results = 0;
	int send_idle = 0;

	hologram_superposition_phase i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
			input int s);
		return v >>> s;
	endfunction

	function automatic void rotate(input logic [31:0] ang, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic neg;
		logic signed [63:0] x, y, z, t;
		neg = 1'b0;
		if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			neg = 1'b1;
			ang = ang - 32'h8000_0000;
		end
		x = 64'sd10188014;
		y = 0;
		z = {{32{ang[31]}}, ang};
		for (int i = 0; i < N_STEPS; i++) begin
			if (z >= 0) begin
				t = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z = z - $signed({32'd0, ATAN_TURNS[i]});
			end else begin
				t = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z = z + $signed({32'd0, ATAN_TURNS[i]});
			end
			x = t;
		end
		x = floor_shr(x + 128, 8);
		y = floor_shr(y + 128, 8);
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic logic [31:0] angle_of(input logic signed [63:0] re,
			input logic signed [63:0] im);
		logic [31:0] base;
		logic signed [63:0] x, y, z, t;
		if (re == 0 && im == 0) return 0;
		base = 0;
		x = re * 256;
		y = im * 256;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = 32'h8000_0000;
		end
		for (int i = 0; i < N_STEPS; i++) begin
			if (y >= 0) begin
				t = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z = z + $signed({32'd0, ATAN_TURNS[i]});
			end else begin
				t = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z = z - $signed({32'd0, ATAN_TURNS[i]});
			end
			x = t;
		end
		return base + z[31:0];
	endfunction

	function automatic logic [15:0] superposed_phase(input logic [15:0] pxw,
			input logic [15:0] pyw);
		logic signed [63:0] px, py, r2, dot, c, s, re, im;
		logic [63:0] prod;
		logic [31:0] ang, ph;
		px = $signed(pxw);
		py = $signed(pyw);
		r2 = px * px + py * py;
		re = 0;
		im = 0;
		for (int k = 0; k < n_used; k++) begin
			dot = tab_x[k] * px + tab_y[k] * py;
			prod = g_lin * dot;
			ang = prod[53:22];
			prod = g_quad * floor_shr(tab_z[k] * r2, 15);
			ang = ang + prod[53:22] + (tab_p[k] << 16);
			rotate(ang, c, s);
			re = re + c;
			im = im + s;
			re = {{40{re[23]}}, re[23:0]};
			im = {{40{im[23]}}, im[23:0]};
		end
		ph = angle_of(re, im) + 32'h8000;
		return ph[31:16];
	endfunction

	task automatic write_reg(input reg_index_t r, input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (r)
			REG_SPOT_COUNT: n_used = (v[6:0] > N_SPOTS) ? N_SPOTS : v[6:0];
			REG_LIN_GAIN: g_lin = $signed(v);
			REG_QUAD_GAIN: g_quad = $signed(v);
			default: ;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while ((phase_q.size() != 0 || busy) && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send(input stim_row_t r);
		while ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		command <= r.cmd;
		spot_index <= r.idx;
		spot_x <= r.sx;
		spot_y <= r.sy;
		spot_z <= r.sz;
		spot_piston <= r.sp;
		pupil_x <= r.px;
		pupil_y <= r.py;
		last_point <= r.last;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.cmd == CMD_LOAD) begin
			tab_x[r.idx] = $signed(r.sx);
			tab_y[r.idx] = $signed(r.sy);
			tab_z[r.idx] = $signed(r.sz);
			tab_p[r.idx] = r.sp;
		end else begin
			phase_q.push_back('{r.check ? r.phase : superposed_phase(r.px, r.py), r.last});
		end
		@(negedge clk);
	endtask

	function automatic stim_row_t spot_row(input logic [5:0] i);
		stim_row_t r;
		r = '{CMD_LOAD, i, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 1'($urandom), 1'b0, 16'd0};
		return r;
	endfunction

	function automatic stim_row_t point_row(input logic [15:0] px, input logic [15:0] py);
		stim_row_t r;
		r = '{CMD_COMPUTE, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), px, py, 1'($urandom), 1'b0, 16'd0};
		return r;
	endfunction

	always @(posedge clk) begin
		phase_word_t exp_w;
		if (done) begin
			n_results++;
			if (phase_q.size() == 0) begin
				report($sformatf("unexpected word phase %0d", phase_out));
			end else begin
				exp_w = phase_q.pop_front();
				if (phase_out !== exp_w.phase)
					report($sformatf("phase_out %0d, want %0d", phase_out,
						$signed(exp_w.phase)));
				if (last_point_out !== exp_w.last)
					report($sformatf("last_point_out %b, want %b", last_point_out,
						exp_w.last));
			end
		end
	end

	initial begin
		stim_row_t dir_tab[$];
		stim_row_t r;
		logic [31:0] gains[6];
		int total, cnt;
		n_used = 0;
		g_lin = 0;
		g_quad = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With no spots in use the sum is zero, so the phase is zero.
		dir_tab.push_back('{CMD_COMPUTE, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'h7fff, 16'h8000, 1'b1, 1'b1, 16'd0});
		dir_tab.push_back('{CMD_LOAD, 6'd0, 16'h0, 16'h0, 16'h0, 16'h8000,
			16'h0, 16'h0, 1'b0, 1'b0, 16'd0});
		dir_tab.push_back('{CMD_LOAD, 6'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff,
			16'hffff, 16'hffff, 1'b1, 1'b0, 16'd0});
		dir_tab.push_back('{CMD_LOAD, 6'd63, 16'h8000, 16'h7fff, 16'h8000, 16'h0,
			16'h0, 16'h0, 1'b0, 1'b0, 16'd0});
		foreach (dir_tab[i]) send(dir_tab[i]);
		dir_tab.delete();
		drain();
		// One spot with half a turn of piston lies on the negative real axis.
		write_reg(REG_SPOT_COUNT, 32'd1);
		write_reg(REG_LIN_GAIN, 32'h7fff_ffff);
		write_reg(REG_QUAD_GAIN, 32'h8000_0000);
		dir_tab.push_back('{CMD_COMPUTE, 6'd5, 16'h1234, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0, 1'b0, 1'b1, 16'h8000});
		dir_tab.push_back('{CMD_COMPUTE, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h7fff, 16'h7fff, 1'b1, 1'b0, 16'd0});
		dir_tab.push_back('{CMD_COMPUTE, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0});
		foreach (dir_tab[i]) send(dir_tab[i]);
		dir_tab.delete();
		drain();
		write_reg(REG_SPOT_COUNT, 32'd127);
		for (int i = 2; i < 63; i++) send(spot_row(6'(i)));
		send(point_row(16'h7fff, 16'h8000));
		send(point_row(16'h8000, 16'h7fff));
		send(point_row(16'h0, 16'h0));
		drain();

		gains = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000,
			32'hff00_0000, 32'h0000_0001};
		total = 0;
		for (int phase = 0; phase < 12; phase++) begin
			send_idle = (phase < 4) ? 28 : (phase < 8) ? 86 : 0;
			cnt = (phase % 3 == 0) ? 64 : $urandom_range(1, 16);
			write_reg(REG_SPOT_COUNT, 32'(cnt));
			write_reg(REG_LIN_GAIN, (phase < 6) ? gains[phase] : $urandom);
			write_reg(REG_QUAD_GAIN, (phase < 6) ? gains[5 - phase] : $urandom);
			while (total < (phase + 1) * 150) begin
				if ($urandom_range(99) < 30)
					r = spot_row(6'($urandom_range(0, 63)));
				else
					r = point_row(16'($urandom), 16'($urandom));
				send(r);
				total++;
			end
			drain();
		end

		$display("Sent %0d random words over 12 gain and spot count settings;", total);
		$display("checked %0d phase words.", n_results);
		if (errors == 0 && phase_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
